// File: design/gtam_pkg.sv
`default_nettype none
package gtam_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = 6;
  localparam int CNT_W        = 7;

  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_ADD_EDGE = 2'd1,
    KIND_BFS      = 2'd2,
    KIND_DFS      = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_BFS_DEQ,
    ST_BFS_CUR,
    ST_BFS_ROW,
    ST_BFS_SCAN,
    ST_DFS_RD,
    ST_DFS_SCAN,
    ST_DFS_POP,
    ST_FLUSH
  } state_t;

  // lowest set bit of a row, binary search over halves
  function automatic logic [VTX_W-1:0] lowest_set(input logic [MAX_VERTICES-1:0] v);
    logic [MAX_VERTICES-1:0] w;
    logic [MAX_VERTICES-1:0] low;
    logic [VTX_W-1:0]        idx;
    int                      s;
    w   = v;
    idx = '0;
    for (s = VTX_W - 1; s >= 0; s--) begin
      low = (MAX_VERTICES'(1) << (1 << s)) - MAX_VERTICES'(1);
      if ((w & low) == '0) begin
        idx[s] = 1'b1;
        w      = w >> (1 << s);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: design/gtam_ram.sv
`default_nettype none
module gtam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: design/graph_traversal_adjacency_matrix_unit.sv
`default_nettype none
// clear: takes effect at once; add edge: row read, then write-back; ready again right after
// breadth-first walk: dequeue, queue read, row read, then one scan step per queued neighbor
// depth-first walk: row read and scan per descent, stack pop and rescan per backtrack, plus a final flush
// both walks share the one row memory and the one lowest-set-bit unit
// sync reset: matrix reads empty (row valid flags), vertex count 64, no item pending
module graph_traversal_adjacency_matrix_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_kind,
  input  wire logic [gtam_pkg::VTX_W-1:0]  in_first_vertex,
  input  wire logic [gtam_pkg::VTX_W-1:0]  in_second_vertex,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [gtam_pkg::VTX_W-1:0]  out_visited_vertex,
  output logic                             out_is_last,
  input  wire logic                        cfg_wr_en,
  input  wire logic [gtam_pkg::CNT_W-1:0]  cfg_wr_data
);

  import gtam_pkg::*;

  localparam int NV = MAX_VERTICES;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] vcount_r;
  logic [NV-1:0]    row_vld_r, row_vld_nxt;
  logic             row_hit_r, row_hit_nxt;
  logic [NV-1:0]    visited_r, visited_nxt;
  logic [NV-1:0]    cand_r, cand_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [VTX_W-1:0] pend_v_r, pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0] out_v_r, out_v_nxt;
  logic             out_last_r, out_last_nxt;
  logic [VTX_W-1:0] cur_r, cur_nxt;
  logic [VTX_W-1:0] a_r, a_nxt;
  logic [VTX_W-1:0] b_r, b_nxt;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;

  logic             row_we, row_re;
  logic [VTX_W-1:0] row_waddr, row_raddr;
  logic [NV-1:0]    row_wdata, row_rdata;
  logic             lst_we, lst_re;
  logic [VTX_W-1:0] lst_waddr, lst_raddr, lst_wdata, lst_rdata;

  logic [CNT_W-1:0] lim;
  logic [NV-1:0]    lim_mask;
  logic [NV-1:0]    eff_row;
  logic [NV-1:0]    dfs_cand;
  logic [VTX_W-1:0] pick;
  logic             out_free;
  logic [CNT_W-1:0] sp_less2;

  gtam_ram #(.WIDTH(NV), .DEPTH(NV)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // queue for breadth-first, stack for depth-first: never both in one walk
  gtam_ram #(.WIDTH(VTX_W), .DEPTH(NV)) u_list (
    .clk   (clk),
    .we    (lst_we),
    .waddr (lst_waddr),
    .wdata (lst_wdata),
    .re    (lst_re),
    .raddr (lst_raddr),
    .rdata (lst_rdata)
  );

  always_comb begin
    lim = (vcount_r > CNT_W'(NV)) ? CNT_W'(NV) : vcount_r;
    for (int i = 0; i < NV; i++) begin
      lim_mask[i] = (CNT_W'(i) < lim);
    end
  end

  assign eff_row  = row_hit_r ? row_rdata : '0;
  assign dfs_cand = eff_row & ~visited_r & lim_mask;
  // one priority encoder serves both walks
  assign pick     = lowest_set((state_r == ST_DFS_SCAN) ? dfs_cand : cand_r);
  assign out_free = !out_valid_r || out_ready;
  assign sp_less2 = sp_r - CNT_W'(2);

  always_comb begin
    state_nxt     = state_r;
    row_vld_nxt   = row_vld_r;
    row_hit_nxt   = row_hit_r;
    visited_nxt   = visited_r;
    cand_nxt      = cand_r;
    pend_vld_nxt  = pend_vld_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_v_nxt     = out_v_r;
    out_last_nxt  = out_last_r;
    cur_nxt       = cur_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    sp_nxt        = sp_r;
    in_ready      = 1'b0;
    row_we        = 1'b0;
    row_waddr     = a_r;
    row_wdata     = eff_row | (NV'(1) << b_r);
    row_re        = 1'b0;
    row_raddr     = cur_r;
    lst_we        = 1'b0;
    lst_waddr     = tail_r[VTX_W-1:0];
    lst_wdata     = pick;
    lst_re        = 1'b0;
    lst_raddr     = head_r[VTX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          a_nxt = in_first_vertex;
          b_nxt = in_second_vertex;
          case (kind_t'(in_kind))
            KIND_CLEAR: begin
              row_vld_nxt = '0;
            end
            KIND_ADD_EDGE: begin
              if ((CNT_W'(in_first_vertex) < lim) && (CNT_W'(in_second_vertex) < lim)) begin
                row_re    = 1'b1;
                row_raddr = in_first_vertex;
                state_nxt = ST_EDGE_WR;
              end
            end
            KIND_BFS: begin
              if (CNT_W'(in_first_vertex) < lim) begin
                visited_nxt = NV'(1) << in_first_vertex;
                lst_we      = 1'b1;
                lst_waddr   = '0;
                lst_wdata   = in_first_vertex;
                head_nxt    = '0;
                tail_nxt    = CNT_W'(1);
                state_nxt   = ST_BFS_DEQ;
              end
            end
            KIND_DFS: begin
              if (CNT_W'(in_first_vertex) < lim) begin
                visited_nxt  = NV'(1) << in_first_vertex;
                pend_vld_nxt = 1'b1;
                pend_v_nxt   = in_first_vertex;
                lst_we       = 1'b1;
                lst_waddr    = '0;
                lst_wdata    = in_first_vertex;
                sp_nxt       = CNT_W'(1);
                cur_nxt      = in_first_vertex;
                state_nxt    = ST_DFS_RD;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_EDGE_WR: begin
        row_we           = 1'b1;
        row_vld_nxt[a_r] = 1'b1;
        state_nxt        = ST_IDLE;
      end

      ST_BFS_DEQ: begin
        if (head_r == tail_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          lst_re    = 1'b1;
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = ST_BFS_CUR;
        end
      end

      ST_BFS_CUR: begin
        cur_nxt   = lst_rdata;
        row_re    = 1'b1;
        row_raddr = lst_rdata;
        state_nxt = ST_BFS_ROW;
      end

      ST_BFS_ROW: begin
        // previous vertex goes out once the next one is known not to be last
        if (!pend_vld_r || out_free) begin
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_v_nxt     = pend_v_r;
            out_last_nxt  = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_v_nxt   = cur_r;
          cand_nxt     = eff_row & ~visited_r & lim_mask;
          state_nxt    = ST_BFS_SCAN;
        end
      end

      ST_BFS_SCAN: begin
        if (cand_r == '0) begin
          state_nxt = ST_BFS_DEQ;
        end else begin
          lst_we            = 1'b1;
          tail_nxt          = tail_r + CNT_W'(1);
          visited_nxt[pick] = 1'b1;
          cand_nxt[pick]    = 1'b0;
        end
      end

      ST_DFS_RD: begin
        row_re    = 1'b1;
        row_raddr = cur_r;
        state_nxt = ST_DFS_SCAN;
      end

      ST_DFS_SCAN: begin
        if (dfs_cand != '0) begin
          if (out_free) begin
            out_valid_nxt     = 1'b1;
            out_v_nxt         = pend_v_r;
            out_last_nxt      = 1'b0;
            pend_v_nxt        = pick;
            visited_nxt[pick] = 1'b1;
            lst_we            = 1'b1;
            lst_waddr         = sp_r[VTX_W-1:0];
            lst_wdata         = pick;
            sp_nxt            = sp_r + CNT_W'(1);
            cur_nxt           = pick;
            state_nxt         = ST_DFS_RD;
          end
        end else if (sp_r == CNT_W'(1)) begin
          sp_nxt    = '0;
          state_nxt = ST_FLUSH;
        end else begin
          // pop: new top sits one below the old one
          lst_re    = 1'b1;
          lst_raddr = sp_less2[VTX_W-1:0];
          sp_nxt    = sp_r - CNT_W'(1);
          state_nxt = ST_DFS_POP;
        end
      end

      ST_DFS_POP: begin
        cur_nxt   = lst_rdata;
        row_re    = 1'b1;
        row_raddr = lst_rdata;
        state_nxt = ST_DFS_SCAN;
      end

      ST_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_v_nxt     = pend_v_r;
          out_last_nxt  = 1'b1;
          pend_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (row_re) begin
      row_hit_nxt = row_vld_r[row_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= CNT_W'(NV);
      row_vld_r   <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      sp_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      row_vld_r   <= row_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      sp_r        <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_hit_r  <= row_hit_nxt;
    visited_r  <= visited_nxt;
    cand_r     <= cand_nxt;
    pend_v_r   <= pend_v_nxt;
    out_v_r    <= out_v_nxt;
    out_last_r <= out_last_nxt;
    cur_r      <= cur_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_visited_vertex = out_v_r;
  assign out_is_last        = out_last_r;

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import gtam_pkg::*;

  localparam int ITEM_TARGET  = 370;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
  } visit_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  kind_t                in_kind = KIND_CLEAR;
  logic [VTX_W-1:0]     in_first_vertex = '0;
  logic [VTX_W-1:0]     in_second_vertex = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VTX_W-1:0]     out_visited_vertex;
  logic                 out_is_last;
  logic                 cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]     cfg_wr_data = '0;

  // shadow of the block state
  logic [MAX_VERTICES-1:0] adj_row [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] seen;
  int unsigned             vcount;
  logic [VTX_W-1:0]        walk_order [$];
  visit_t                  pending_visits [$];

  int error_count = 0;
  int items_sent = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  graph_traversal_adjacency_matrix_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_first_vertex   (in_first_vertex),
    .in_second_vertex  (in_second_vertex),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_visited_vertex(out_visited_vertex),
    .out_is_last       (out_is_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int active_limit();
    return (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
  endfunction

  function automatic void bfs_visit_order(input int start, input int lim);
    logic [VTX_W-1:0] fifo [MAX_VERTICES];
    int head;
    int tail;
    int cur;
    head = 0;
    tail = 1;
    seen[start] = 1'b1;
    fifo[0] = VTX_W'(start);
    while (head < tail && head < MAX_VERTICES) begin
      cur = fifo[head];
      head++;
      if (walk_order.size() < MAX_VERTICES) walk_order.push_back(VTX_W'(cur));
      for (int i = 0; i < lim; i++) begin
        if (adj_row[cur][i] && !seen[i] && tail < MAX_VERTICES) begin
          seen[i] = 1'b1;
          fifo[tail] = VTX_W'(i);
          tail++;
        end
      end
    end
  endfunction

  // explicit stack of (vertex, resume index) instead of recursion
  function automatic void dfs_visit_order(input int start, input int lim);
    int stk_vertex [MAX_VERTICES];
    int stk_resume [MAX_VERTICES];
    int sp;
    int v;
    int i;
    seen[start] = 1'b1;
    walk_order.push_back(VTX_W'(start));
    stk_vertex[0] = start;
    stk_resume[0] = 0;
    sp = 1;
    while (sp > 0) begin
      v = stk_vertex[sp-1];
      i = stk_resume[sp-1];
      while (i < lim && !(adj_row[v][i] && !seen[i])) i++;
      if (i < lim && sp < MAX_VERTICES) begin
        stk_resume[sp-1] = i + 1;
        seen[i] = 1'b1;
        if (walk_order.size() < MAX_VERTICES) walk_order.push_back(VTX_W'(i));
        stk_vertex[sp] = i;
        stk_resume[sp] = 0;
        sp++;
      end else begin
        sp--;
      end
    end
  endfunction

  function automatic void model_command(input kind_t k, input logic [VTX_W-1:0] a,
                                        input logic [VTX_W-1:0] b);
    int lim;
    visit_t vis;
    lim = active_limit();
    case (k)
      KIND_CLEAR: begin
        for (int r = 0; r < MAX_VERTICES; r++) adj_row[r] = '0;
      end
      KIND_ADD_EDGE: begin
        if (int'(a) < lim && int'(b) < lim) adj_row[a][b] = 1'b1;
      end
      default: begin
        seen = '0;
        walk_order.delete();
        if (int'(a) < lim) begin
          if (k == KIND_BFS) bfs_visit_order(int'(a), lim);
          else dfs_visit_order(int'(a), lim);
        end
        foreach (walk_order[n]) begin
          vis.vertex = walk_order[n];
          vis.last   = (n == walk_order.size() - 1);
          pending_visits.push_back(vis);
        end
      end
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_visit(input logic [VTX_W-1:0] vertex, input logic last);
    visit_t exp;
    if (pending_visits.size() == 0) begin
      report_error($sformatf("unexpected visit vertex=%0d last=%0b", vertex, last));
    end else begin
      exp = pending_visits.pop_front();
      if (vertex !== exp.vertex)
        report_error($sformatf("visited_vertex got %0d want %0d", vertex, exp.vertex));
      if (last !== exp.last)
        report_error($sformatf("is_last got %0b want %0b (vertex %0d)", last, exp.last,
                               exp.vertex));
    end
  endtask

  // result side: random stall after each accepted item, none in steady phases
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_visit(out_visited_vertex, out_is_last);
        stall_left = steady ? 0 : $urandom_range(0, 3);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      out_ready <= (stall_left == 0);
    end
  end

  task automatic send_item(input kind_t k, input logic [VTX_W-1:0] a,
                           input logic [VTX_W-1:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= k;
    in_first_vertex  <= a;
    in_second_vertex <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_command(k, a, b);
    items_sent++;
  endtask

  // idle the input, let all visits drain and the walk engine wind down
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_visits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int unsigned count);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(count);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vcount = count & 7'h7f;
  endtask

  function automatic logic [VTX_W-1:0] pick_vertex(input int lim);
    int r;
    r = $urandom_range(0, 9);
    if (lim == 0 || r == 0) return VTX_W'($urandom_range(0, 63));
    // dense low corner keeps walks long
    if (r < 5) return VTX_W'($urandom_range(0, ((lim < 12) ? lim : 12) - 1));
    return VTX_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic test_empty_graph();
    send_item(KIND_BFS, 6'd0, 6'd63);
    send_item(KIND_DFS, 6'd63, 6'd0);
  endtask

  task automatic test_small_walks();
    send_item(KIND_ADD_EDGE, 6'd0, 6'd2);
    send_item(KIND_ADD_EDGE, 6'd0, 6'd1);
    send_item(KIND_ADD_EDGE, 6'd1, 6'd3);
    send_item(KIND_ADD_EDGE, 6'd2, 6'd3);
    send_item(KIND_ADD_EDGE, 6'd3, 6'd0);
    send_item(KIND_ADD_EDGE, 6'd2, 6'd63);
    send_item(KIND_ADD_EDGE, 6'd63, 6'd5);
    send_item(KIND_ADD_EDGE, 6'd5, 6'd5);
    send_item(KIND_BFS, 6'd0, 6'd42);
    send_item(KIND_DFS, 6'd0, 6'd21);
    send_item(KIND_DFS, 6'd63, 6'd63);
  endtask

  task automatic test_vertex_count_limits();
    write_vertex_count(4);
    send_item(KIND_ADD_EDGE, 6'd0, 6'd4);
    send_item(KIND_ADD_EDGE, 6'd4, 6'd0);
    send_item(KIND_BFS, 6'd4, 6'd0);
    send_item(KIND_DFS, 6'd0, 6'd0);
    // edge into 63 stays in the matrix but is out of view
    send_item(KIND_BFS, 6'd2, 6'd0);
    write_vertex_count(0);
    send_item(KIND_BFS, 6'd0, 6'd0);
    send_item(KIND_ADD_EDGE, 6'd0, 6'd0);
    // above the maximum saturates to all vertices
    write_vertex_count(127);
    send_item(KIND_DFS, 6'd2, 6'd0);
    write_vertex_count(1);
    send_item(KIND_BFS, 6'd0, 6'd0);
    write_vertex_count(64);
  endtask

  task automatic test_clear();
    send_item(KIND_CLEAR, 6'd63, 6'd63);
    send_item(KIND_BFS, 6'd0, 6'd0);
    send_item(KIND_DFS, 6'd2, 6'd0);
  endtask

  task automatic test_random_graphs();
    int unsigned count;
    int lim;
    int phase_len;
    int r;
    int chain_at;
    bit chain_mode;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 15);
      if (r == 0) count = 0;
      else if (r <= 2) count = $urandom_range(1, 2);
      else if (r <= 5) count = 64;
      else if (r <= 7) count = $urandom_range(65, 127);
      else count = $urandom_range(3, 63);
      write_vertex_count(count);
      steady     = ($urandom_range(0, 3) == 0);
      lim        = active_limit();
      chain_mode = (lim > 1) && ($urandom_range(0, 4) == 0);
      phase_len  = chain_mode ? lim + 8 : $urandom_range(20, 45);
      chain_at   = 0;
      if ($urandom_range(0, 1))
        send_item(KIND_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
      for (int k = 0; k < phase_len; k++) begin
        r = $urandom_range(0, 99);
        if (chain_mode && r < 75) begin
          send_item(KIND_ADD_EDGE, VTX_W'(chain_at), VTX_W'((chain_at + 1) % lim));
          chain_at = (chain_at + 1) % lim;
        end else if (!chain_mode && r < 3) begin
          send_item(KIND_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
        end else if (r < 60) begin
          send_item(KIND_ADD_EDGE, pick_vertex(lim), pick_vertex(lim));
        end else if (r < 80 || (chain_mode && r < 88)) begin
          send_item(KIND_BFS, pick_vertex(lim), VTX_W'($urandom));
        end else begin
          send_item(KIND_DFS, pick_vertex(lim), VTX_W'($urandom));
        end
      end
      if (chain_mode) begin
        send_item(KIND_BFS, 6'd0, VTX_W'($urandom));
        send_item(KIND_DFS, 6'd0, VTX_W'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    vcount = 64;
    seen   = '0;
    for (int r = 0; r < MAX_VERTICES; r++) adj_row[r] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_graph();
    test_small_walks();
    test_vertex_count_limits();
    test_clear();
    test_random_graphs();
    settle_block();
    if (error_count == 0) begin
      $display("** graph_traversal_adjacency_matrix_unit: PASSED **");
    end else begin
      $display("** graph_traversal_adjacency_matrix_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("timeout, %0d visits still pending", pending_visits.size());
    $display("** graph_traversal_adjacency_matrix_unit: FAILED **");
    $finish;
  end

endmodule
